// File: hdl/cfc_pkg.sv
// Package for the CRC-16 frame checker: request types, byte classes and CRC helpers.
package cfc_pkg;

    localparam int unsigned HDR_BYTES   = 16;
    localparam int unsigned LEN_LO_POS  = 14;
    localparam int unsigned LEN_HI_POS  = 15;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [1:0] VERDICT_PENDING  = 2'd0;
    localparam logic [1:0] VERDICT_GOOD     = 2'd1;
    localparam logic [1:0] VERDICT_CRC_FAIL = 2'd2;

    localparam logic [15:0] NIB_TAB [16] = '{
        16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
        16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] payload_length;
        logic [15:0] computed_crc;
    } t_out;

    // What the back end has to do with a byte
    typedef enum logic [1:0] {
        K_IGNORE  = 2'd0,
        K_CRC     = 2'd1,
        K_CRC_LOW = 2'd2,
        K_CRC_HI  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        frame_start;
        logic [7:0]  data_byte;
        logic [15:0] length;
    } t_qent;

    function automatic logic [15:0] crc_nibble(input logic [15:0] c, input logic [3:0] nib);
        logic [3:0] idx;
        idx = c[15:12] ^ nib;
        return {c[11:0], 4'h0} ^ NIB_TAB[idx];
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] mid;
        mid = crc_nibble(c, b[7:4]);
        return crc_nibble(mid, b[3:0]);
    endfunction

endpackage

// File: hdl/crc16_frame_checker.sv
// Top level of the CRC-16 frame checker: front end, request queue, back end.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | input     | i_valid / o_ready  | i_in  : data_byte, frame_start
//  out     | output    | o_valid / i_ready  | o_out : verdict, payload_length, computed_crc
//
//  One request per cycle sustained while the output is not stalled; each byte yields
//  exactly one result (queue write when the byte is taken, back-end CRC step into the
//  output register when the entry is popped).
//  The front end decides byte position and length combinationally as a byte is taken.
//  Reset (synchronous, active low) clears frame tracking, CRC, queue and output valid.
//  A stalled output holds its result; the queue absorbs bytes until full, then o_ready drops.
module crc16_frame_checker
    import cfc_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_in,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_out
);

    // front -> queue
    logic  push;
    t_qent push_ent;
    logic  q_full;

    // queue -> back
    logic  q_valid;
    t_qent q_ent;
    logic  pop;

    // Front: tracks byte index, header length and frame activity. Everything the
    // back end needs except the CRC itself is decided here, so the back end never
    // has to look at the counter.
    cfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_ready  (o_ready),
        .o_push   (push),
        .o_ent    (push_ent)
    );

    cfc_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    // Back: nibble-table CRC over header and payload, latches the low trailer
    // byte, compares on the high trailer byte. Output register doubles as skid.
    cfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_ent     (q_ent),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (o_out)
    );

endmodule

// File: hdl/cfc_front.sv
// Front end: accepts bytes, tracks frame position and length, classifies each byte.
module cfc_front
    import cfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_in   i_in,
    input  logic  i_q_full,
    output logic  o_ready,
    output logic  o_push,
    output t_qent o_ent
);

    logic [16:0] r_byte_count, n_byte_count;
    logic [15:0] r_length, n_length;
    logic        r_active, n_active;

    logic [16:0] idx;
    logic [15:0] len_base;
    logic        act_base;
    logic [16:0] crc_end;
    t_kind       kind;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        idx      = i_in.frame_start ? '0 : r_byte_count;
        len_base = i_in.frame_start ? '0 : r_length;
        act_base = i_in.frame_start || r_active;
        crc_end  = 17'(HDR_BYTES) + {1'b0, len_base};

        kind         = K_IGNORE;
        n_length     = len_base;
        n_active     = act_base;
        n_byte_count = idx;

        if (act_base) begin
            if (idx < crc_end) begin
                kind = K_CRC;
                if (idx == 17'(LEN_LO_POS)) begin
                    n_length = {len_base[15:8], i_in.data_byte};
                end else if (idx == 17'(LEN_HI_POS)) begin
                    n_length = {i_in.data_byte, len_base[7:0]};
                end
            end else if (idx == crc_end) begin
                kind = K_CRC_LOW;
            end else begin
                kind     = K_CRC_HI;
                n_active = 1'b0;
            end
            n_byte_count = idx + 17'd1;
        end
    end

    always_comb begin
        o_ent.kind        = kind;
        o_ent.frame_start = i_in.frame_start;
        o_ent.data_byte   = i_in.data_byte;
        o_ent.length      = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_length     <= '0;
            r_active     <= 1'b0;
        end else if (o_push) begin
            r_byte_count <= n_byte_count;
            r_length     <= n_length;
            r_active     <= n_active;
        end
    end

endmodule

// File: hdl/cfc_queue.sv
// Small FIFO of classified requests between front and back ends.
module cfc_queue
    import cfc_pkg::*;
#(
    parameter int unsigned P_DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_ent
);

    localparam int unsigned PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    t_qent           r_mem [P_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rd_ptr];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(P_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: hdl/cfc_back.sv
// Back end: CRC update, trailer compare and the output register.
module cfc_back
    import cfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_qent i_ent,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_out
);

    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_low, n_crc_low;
    logic        r_out_valid;
    t_out        r_out, n_out;
    logic [15:0] crc_base;

    assign o_pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    always_comb begin
        crc_base  = i_ent.frame_start ? '0 : r_crc;
        n_crc     = crc_base;
        n_crc_low = i_ent.frame_start ? '0 : r_crc_low;
        n_out.verdict = VERDICT_PENDING;
        unique case (i_ent.kind)
            K_IGNORE: ;
            K_CRC:     n_crc = crc_byte(crc_base, i_ent.data_byte);
            K_CRC_LOW: n_crc_low = i_ent.data_byte;
            K_CRC_HI:  n_out.verdict = ({i_ent.data_byte, n_crc_low} == crc_base)
                                       ? VERDICT_GOOD : VERDICT_CRC_FAIL;
            default: ;
        endcase
        n_out.payload_length = i_ent.length;
        n_out.computed_crc   = n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_crc_low   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_crc       <= n_crc;
                r_crc_low   <= n_crc_low;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule
